// ----- rtl/core/spi_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment pair intersection package
// Widths, payload types, context records and small arithmetic helpers that
// the front end, the divider and the top level share.
// ----------------------------------------------------------------------------
package spi_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;

    localparam int TOL_W     = FRACTION_BITS + 1;
    localparam int PARAM_W   = FRACTION_BITS + 1;
    localparam int DIFF_W    = COORD_WIDTH + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int NUM_W     = SUM_W + FRACTION_BITS;
    localparam int EPSF_W    = TOL_W + FRACTION_BITS;
    localparam int EPSSQ_W   = 2 * TOL_W;
    localparam int DIV_STEPS = FRACTION_BITS + 2;
    localparam int QUOT_W    = DIV_STEPS + 1;
    localparam int QSIGN_W   = QUOT_W + 1;
    localparam int DIV_LAT   = DIV_STEPS + 3;
    localparam int LERP_W    = DIFF_W + PARAM_W + 1;
    localparam int PIPE_LAT  = 4 + 2 * DIV_LAT + 8;

    localparam logic [PARAM_W-1:0] PARAM_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic signed [NUM_W-1:0]       num_t;
    typedef logic signed [QSIGN_W-1:0]     quot_t;
    typedef logic [PARAM_W-1:0]            param_t;
    typedef logic [TOL_W-1:0]              tol_t;

    typedef enum logic [1:0] {
        REL_NONE    = 2'd0,
        REL_POINT   = 2'd1,
        REL_OVERLAP = 2'd2
    } rel_t;

    typedef struct packed {
        coord_t a_start_x;
        coord_t a_start_y;
        coord_t a_end_x;
        coord_t a_end_y;
        coord_t b_start_x;
        coord_t b_start_y;
        coord_t b_end_x;
        coord_t b_end_y;
    } seg_in_t;

    typedef struct packed {
        rel_t   relation;
        param_t param_first;
        param_t param_second;
        coord_t hit_x;
        coord_t hit_y;
    } seg_out_t;

    // Geometry of one pair as it travels next to the first two divisions.
    typedef struct packed {
        logic   col;
        logic   rxs_small;
        logic   rr_small;
        logic   qq_small;
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        diff_t  rx;
        diff_t  ry;
        diff_t  sx;
        diff_t  sy;
        sum_t   ss;
    } ctx_t;

    typedef struct packed {
        ctx_t ctx;
        num_t num_a;
        num_t num_b;
        sum_t den;
    } front_t;

    // Partial result as it travels next to the on-segment division.
    typedef struct packed {
        rel_t   rel;
        param_t ta;
        param_t tb;
        logic   narrow;
        logic   on_line;
        logic   ss_small;
        coord_t hx;
        coord_t hy;
    } ctx2_t;

    function automatic prod_t mul(diff_t a, diff_t b);
        return PROD_W'(a) * PROD_W'(b);
    endfunction

    function automatic logic abs_le(sum_t v, logic [EPSF_W-1:0] lim);
        sum_t l;
        l = $signed(SUM_W'(lim));
        return (v <= l) && (v >= -l);
    endfunction

    function automatic logic le_sq(sum_t v, logic [EPSSQ_W-1:0] lim);
        return v <= $signed(SUM_W'(lim));
    endfunction

    function automatic num_t shl_frac(sum_t v);
        return $signed({v, {FRACTION_BITS{1'b0}}});
    endfunction

    function automatic param_t clamp_param(quot_t t);
        quot_t one;
        one = $signed(QSIGN_W'(PARAM_ONE));
        if (t < 0)
        begin
            return '0;
        end
        if (t > one)
        begin
            return PARAM_ONE;
        end
        return t[PARAM_W-1:0];
    endfunction

    function automatic logic in_band(quot_t t, tol_t eps);
        quot_t e;
        quot_t one;
        e   = $signed(QSIGN_W'(eps));
        one = $signed(QSIGN_W'(PARAM_ONE));
        return (t >= -e) && (t <= one + e);
    endfunction

endpackage

// ----- rtl/core/segment_pair_intersect.sv -----
// ----------------------------------------------------------------------------
// Segment pair intersection
// Relation, parameters and hit point of two Q16.16 segments with tolerance.
// ----------------------------------------------------------------------------
// The block takes one segment pair in every clock cycle (busy is always low)
// and delivers each result with one done pulse per transaction, in order.
// Its pipeline holds two 21-stage restoring dividers in series, one quotient
// bit per stage: the first solves the line parameters, the second places a
// narrow-overlap hit point on segment B. The receiver cannot stall the
// result, so it must take each done pulse as it comes. The tolerance
// register resets to 1 and must be written only while no transaction is in
// flight.
module segment_pair_intersect (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  spi_pkg::seg_in_t   segs,
    input  logic               tol_wr_en,
    input  spi_pkg::tol_t      tol_wr_data,
    output logic               done,
    output spi_pkg::seg_out_t  result
);
    localparam int DL = spi_pkg::DIV_LAT;
    localparam int FB = spi_pkg::FRACTION_BITS;

    spi_pkg::tol_t                 tol_reg;
    logic [spi_pkg::EPSSQ_W-1:0]   eps_sq_reg;
    logic [spi_pkg::EPSF_W-1:0]    eps_f;
    spi_pkg::quot_t                eps_q, one_q;

    logic            fv;
    spi_pkg::front_t fr;
    logic            vab, vb_chk;
    spi_pkg::quot_t  qa, qb;
    spi_pkg::ctx_t   ctx_pipe_reg [DL];
    spi_pkg::ctx_t   ctx_d;

    logic            e1_v_reg, e2_v_reg, e3_v_reg, e4_v_reg, e5_v_reg, e6_v_reg, dc_v_reg;
    spi_pkg::ctx2_t  e1_c2_reg, e1_c2_next, e2_c2_reg, e3_c2_reg, e3_c2_next;
    spi_pkg::ctx2_t  e4_c2_reg, e5_c2_reg, e6_c2_reg, dc_c2_reg, dc_c2_next;
    spi_pkg::ctx_t   e1_ctx_reg, e2_ctx_reg, e3_ctx_reg, e4_ctx_reg;
    spi_pkg::sum_t   e5_ss_reg, e6_ss_reg;
    logic signed [spi_pkg::LERP_W-1:0] mx_reg, my_reg, hx_full, hy_full;
    spi_pkg::diff_t  apx_reg, apy_reg;
    spi_pkg::prod_t  p_sx_apy_reg, p_sy_apx_reg, p_apx_sx_reg, p_apy_sy_reg;
    spi_pkg::sum_t   cr_reg, dt_reg;
    spi_pkg::num_t   dc_num_reg;
    spi_pkg::sum_t   dc_den_reg;

    logic            vc;
    spi_pkg::quot_t  qc;
    spi_pkg::ctx2_t  c2_pipe_reg [DL];
    spi_pkg::ctx2_t  c2_d;

    logic              done_reg;
    spi_pkg::seg_out_t result_reg, result_next;

    assign busy  = 1'b0;
    assign eps_f = {tol_reg, {FB{1'b0}}};
    assign eps_q = $signed(spi_pkg::QSIGN_W'(tol_reg));
    assign one_q = $signed(spi_pkg::QSIGN_W'(spi_pkg::PARAM_ONE));

    // The squared tolerance is registered from tol_reg; it is first used four stages in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg    <= spi_pkg::TOL_W'(1);
            eps_sq_reg <= spi_pkg::EPSSQ_W'(1);
        end
        else
        begin
            if (tol_wr_en)
            begin
                tol_reg <= tol_wr_data;
            end
            eps_sq_reg <= spi_pkg::EPSSQ_W'(tol_reg) * spi_pkg::EPSSQ_W'(tol_reg);
        end
    end

    spi_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .segs   (segs),
        .eps_f  (eps_f),
        .eps_sq (eps_sq_reg),
        .valid  (fv),
        .front  (fr)
    );

    spi_div u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fv),
        .num       (fr.num_a),
        .den       (fr.den),
        .out_valid (vab),
        .quot      (qa)
    );

    spi_div u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fv),
        .num       (fr.num_b),
        .den       (fr.den),
        .out_valid (vb_chk),
        .quot      (qb)
    );

    always_ff @(posedge clk)
    begin
        ctx_pipe_reg[0] <= fr.ctx;
        for (int i = 1; i < DL; i++)
        begin
            ctx_pipe_reg[i] <= ctx_pipe_reg[i-1];
        end
    end

    assign ctx_d = ctx_pipe_reg[DL-1];

    // Classification from the two quotients.
    always_comb
    begin
        spi_pkg::quot_t t0, t1, lo, hi, span;
        t0   = (qa < qb) ? qa : qb;
        t1   = (qa < qb) ? qb : qa;
        lo   = (t0 > 0) ? t0 : '0;
        hi   = (t1 < one_q) ? t1 : one_q;
        span = hi - lo;
        e1_c2_next = '0;
        e1_c2_next.rel = spi_pkg::REL_NONE;
        if (ctx_d.col)
        begin
            if (ctx_d.rr_small)
            begin
                // A degenerate A only meets B at a shared start point.
                if (ctx_d.qq_small)
                begin
                    e1_c2_next.rel = spi_pkg::REL_POINT;
                end
            end
            else if (!(hi < -eps_q || lo > one_q + eps_q || hi < lo - eps_q))
            begin
                if (span <= eps_q)
                begin
                    e1_c2_next.rel    = spi_pkg::REL_POINT;
                    e1_c2_next.ta     = spi_pkg::clamp_param(lo);
                    e1_c2_next.narrow = 1'b1;
                end
                else
                begin
                    e1_c2_next.rel = spi_pkg::REL_OVERLAP;
                    e1_c2_next.ta  = spi_pkg::clamp_param(lo);
                    e1_c2_next.tb  = spi_pkg::clamp_param(hi);
                end
            end
        end
        else if (!ctx_d.rxs_small)
        begin
            if (spi_pkg::in_band(qa, tol_reg) && spi_pkg::in_band(qb, tol_reg))
            begin
                e1_c2_next.rel = spi_pkg::REL_POINT;
                e1_c2_next.ta  = spi_pkg::clamp_param(qa);
                e1_c2_next.tb  = spi_pkg::clamp_param(qb);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_v_reg <= 1'b0;
            e2_v_reg <= 1'b0;
            e3_v_reg <= 1'b0;
            e4_v_reg <= 1'b0;
            e5_v_reg <= 1'b0;
            e6_v_reg <= 1'b0;
            dc_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            e1_v_reg <= vab;
            e2_v_reg <= e1_v_reg;
            e3_v_reg <= e2_v_reg;
            e4_v_reg <= e3_v_reg;
            e5_v_reg <= e4_v_reg;
            e6_v_reg <= e5_v_reg;
            dc_v_reg <= e6_v_reg;
            done_reg <= vc;
        end
    end

    always_comb
    begin
        hx_full = spi_pkg::LERP_W'(e2_ctx_reg.ax) + (mx_reg >>> FB);
        hy_full = spi_pkg::LERP_W'(e2_ctx_reg.ay) + (my_reg >>> FB);
        e3_c2_next    = e2_c2_reg;
        e3_c2_next.hx = hx_full[spi_pkg::COORD_WIDTH-1:0];
        e3_c2_next.hy = hy_full[spi_pkg::COORD_WIDTH-1:0];

        dc_c2_next          = e6_c2_reg;
        dc_c2_next.on_line  = spi_pkg::abs_le(cr_reg, eps_f);
        dc_c2_next.ss_small = spi_pkg::le_sq(e6_ss_reg, eps_sq_reg);
    end

    // Hit point on A, then the on-segment test of that point against B.
    always_ff @(posedge clk)
    begin
        e1_c2_reg  <= e1_c2_next;
        e1_ctx_reg <= ctx_d;

        e2_c2_reg  <= e1_c2_reg;
        e2_ctx_reg <= e1_ctx_reg;
        mx_reg     <= spi_pkg::LERP_W'(e1_ctx_reg.rx) *
                      $signed(spi_pkg::LERP_W'(e1_c2_reg.ta));
        my_reg     <= spi_pkg::LERP_W'(e1_ctx_reg.ry) *
                      $signed(spi_pkg::LERP_W'(e1_c2_reg.ta));

        e3_c2_reg  <= e3_c2_next;
        e3_ctx_reg <= e2_ctx_reg;

        e4_c2_reg  <= e3_c2_reg;
        e4_ctx_reg <= e3_ctx_reg;
        apx_reg    <= spi_pkg::DIFF_W'(e3_c2_reg.hx) - spi_pkg::DIFF_W'(e3_ctx_reg.bx);
        apy_reg    <= spi_pkg::DIFF_W'(e3_c2_reg.hy) - spi_pkg::DIFF_W'(e3_ctx_reg.by);

        e5_c2_reg    <= e4_c2_reg;
        e5_ss_reg    <= e4_ctx_reg.ss;
        p_sx_apy_reg <= spi_pkg::mul(e4_ctx_reg.sx, apy_reg);
        p_sy_apx_reg <= spi_pkg::mul(e4_ctx_reg.sy, apx_reg);
        p_apx_sx_reg <= spi_pkg::mul(apx_reg, e4_ctx_reg.sx);
        p_apy_sy_reg <= spi_pkg::mul(apy_reg, e4_ctx_reg.sy);

        e6_c2_reg <= e5_c2_reg;
        e6_ss_reg <= e5_ss_reg;
        cr_reg    <= spi_pkg::SUM_W'(p_sx_apy_reg) - spi_pkg::SUM_W'(p_sy_apx_reg);
        dt_reg    <= spi_pkg::SUM_W'(p_apx_sx_reg) + spi_pkg::SUM_W'(p_apy_sy_reg);

        dc_c2_reg  <= dc_c2_next;
        dc_num_reg <= spi_pkg::shl_frac(dt_reg);
        dc_den_reg <= e6_ss_reg;
    end

    spi_div u_div_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dc_v_reg),
        .num       (dc_num_reg),
        .den       (dc_den_reg),
        .out_valid (vc),
        .quot      (qc)
    );

    always_ff @(posedge clk)
    begin
        c2_pipe_reg[0] <= dc_c2_reg;
        for (int i = 1; i < DL; i++)
        begin
            c2_pipe_reg[i] <= c2_pipe_reg[i-1];
        end
    end

    assign c2_d = c2_pipe_reg[DL-1];

    always_comb
    begin
        result_next.relation     = c2_d.rel;
        result_next.param_first  = c2_d.ta;
        result_next.param_second = c2_d.tb;
        result_next.hit_x        = c2_d.hx;
        result_next.hit_y        = c2_d.hy;
        if (c2_d.narrow)
        begin
            result_next.param_second = '0;
            if (c2_d.on_line && !c2_d.ss_small && spi_pkg::in_band(qc, tol_reg))
            begin
                result_next.param_second = spi_pkg::clamp_param(qc);
            end
        end
        if (c2_d.rel == spi_pkg::REL_NONE)
        begin
            result_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        vab == vb_chk)
        else $error("parameter dividers out of step");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(spi_pkg::PIPE_LAT) done)
        else $error("transaction result missing at fixed latency");

    a_overlap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.relation == spi_pkg::REL_OVERLAP) |->
        (result.param_first < result.param_second))
        else $error("overlap end not past overlap start");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.relation == spi_pkg::REL_NONE) |->
        (result.param_first == '0 && result.param_second == '0 &&
         result.hit_x == '0 && result.hit_y == '0))
        else $error("no-hit result carries data");

    a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.param_first <= spi_pkg::PARAM_ONE &&
                  result.param_second <= spi_pkg::PARAM_ONE))
        else $error("parameter above one");

endmodule

// ----- rtl/core/spi_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Restoring division, one quotient bit per stage, rounded toward minus
// infinity. Quotient magnitudes are saturated well outside the parameter
// range, which is all the callers ever compare against.
// ----------------------------------------------------------------------------
module spi_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  spi_pkg::num_t  num,
    input  spi_pkg::sum_t  den,
    output logic           out_valid,
    output spi_pkg::quot_t quot
);
    localparam int STEPS = spi_pkg::DIV_STEPS;
    localparam int REM_W = spi_pkg::NUM_W + STEPS + 1;
    localparam int QW    = spi_pkg::QUOT_W;

    logic                         v0_reg;
    logic [spi_pkg::NUM_W-1:0]    un_reg;
    logic [spi_pkg::SUM_W-1:0]    ud_reg;
    logic                         neg_reg;

    logic                         v_reg   [STEPS+1];
    logic [REM_W-1:0]             rm_reg  [STEPS+1];
    logic [spi_pkg::SUM_W-1:0]    ud_s_reg[STEPS+1];
    logic [QW-1:0]                q_reg   [STEPS+1];
    logic                         neg_s_reg[STEPS+1];
    logic                         sat_reg [STEPS+1];

    logic                         out_v_reg;
    spi_pkg::quot_t               quot_reg;
    spi_pkg::quot_t               quot_next;
    logic                         sat_next;
    logic [QW-1:0]                qa;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v_reg[0]  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            v0_reg    <= in_valid;
            v_reg[0]  <= v0_reg;
            out_v_reg <= v_reg[STEPS];
        end
    end

    // Signs and magnitudes.
    always_ff @(posedge clk)
    begin
        un_reg  <= spi_pkg::NUM_W'(num[spi_pkg::NUM_W-1] ? -num : num);
        ud_reg  <= spi_pkg::SUM_W'(den[spi_pkg::SUM_W-1] ? -den : den);
        neg_reg <= num[spi_pkg::NUM_W-1] ^ den[spi_pkg::SUM_W-1];
    end

    assign sat_next = REM_W'(un_reg) >= (REM_W'(ud_reg) << STEPS);

    always_ff @(posedge clk)
    begin
        rm_reg[0]    <= REM_W'(un_reg);
        ud_s_reg[0]  <= ud_reg;
        neg_s_reg[0] <= neg_reg;
        sat_reg[0]   <= sat_next;
        q_reg[0]     <= sat_next ? (QW'(1) << STEPS) : '0;
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam int SH = STEPS - 1 - k;
        logic [REM_W-1:0] trial;
        logic             take;

        assign trial = REM_W'(ud_s_reg[k]) << SH;
        assign take  = !sat_reg[k] && (rm_reg[k] >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rm_reg[k+1]    <= take ? (rm_reg[k] - trial) : rm_reg[k];
            q_reg[k+1]     <= take ? (q_reg[k] | (QW'(1) << SH)) : q_reg[k];
            ud_s_reg[k+1]  <= ud_s_reg[k];
            neg_s_reg[k+1] <= neg_s_reg[k];
            sat_reg[k+1]   <= sat_reg[k];
        end
    end

    // A negative quotient with a remainder rounds one further down.
    always_comb
    begin
        qa = q_reg[STEPS];
        if (neg_s_reg[STEPS] && !sat_reg[STEPS] && (rm_reg[STEPS] != '0))
        begin
            qa = q_reg[STEPS] + QW'(1);
        end
        quot_next = neg_s_reg[STEPS] ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
    end

    assign out_valid = out_v_reg;
    assign quot      = quot_reg;

endmodule

// ----- rtl/core/spi_front.sv -----
// ----------------------------------------------------------------------------
// Segment pair front end
// Four stages: edge vectors, products, cross and dot sums, then the
// tolerance tests that pick the branch and the operands of the divisions.
// ----------------------------------------------------------------------------
module spi_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  spi_pkg::seg_in_t            segs,
    input  logic [spi_pkg::EPSF_W-1:0]  eps_f,
    input  logic [spi_pkg::EPSSQ_W-1:0] eps_sq,
    output logic                        valid,
    output spi_pkg::front_t             front
);
    localparam int P_RX_SY = 0;
    localparam int P_RY_SX = 1;
    localparam int P_QX_RY = 2;
    localparam int P_QY_RX = 3;
    localparam int P_RX_RX = 4;
    localparam int P_RY_RY = 5;
    localparam int P_QX_QX = 6;
    localparam int P_QY_QY = 7;
    localparam int P_QX_RX = 8;
    localparam int P_QY_RY = 9;
    localparam int P_WX_RX = 10;
    localparam int P_WY_RY = 11;
    localparam int P_QX_SY = 12;
    localparam int P_QY_SX = 13;
    localparam int P_SX_SX = 14;
    localparam int P_SY_SY = 15;
    localparam int N_PROD  = 16;

    logic           v1_reg, v2_reg, v3_reg, v4_reg;
    spi_pkg::ctx_t  c1_reg, c1_next, c2_reg, c3_reg, c3_next;
    spi_pkg::diff_t qx_reg, qy_reg, wx_reg, wy_reg;
    spi_pkg::prod_t prod_reg  [N_PROD];
    spi_pkg::prod_t prod_next [N_PROD];
    spi_pkg::sum_t  rxs_reg, qpxr_reg, rr_reg, qq_reg, qr_reg, wr_reg, qs_reg;
    spi_pkg::front_t front_reg, front_next;
    logic           col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_comb
    begin
        c1_next    = '0;
        c1_next.ax = segs.a_start_x;
        c1_next.ay = segs.a_start_y;
        c1_next.bx = segs.b_start_x;
        c1_next.by = segs.b_start_y;
        c1_next.rx = spi_pkg::DIFF_W'(segs.a_end_x) - spi_pkg::DIFF_W'(segs.a_start_x);
        c1_next.ry = spi_pkg::DIFF_W'(segs.a_end_y) - spi_pkg::DIFF_W'(segs.a_start_y);
        c1_next.sx = spi_pkg::DIFF_W'(segs.b_end_x) - spi_pkg::DIFF_W'(segs.b_start_x);
        c1_next.sy = spi_pkg::DIFF_W'(segs.b_end_y) - spi_pkg::DIFF_W'(segs.b_start_y);
    end

    always_ff @(posedge clk)
    begin
        c1_reg <= c1_next;
        qx_reg <= spi_pkg::DIFF_W'(segs.b_start_x) - spi_pkg::DIFF_W'(segs.a_start_x);
        qy_reg <= spi_pkg::DIFF_W'(segs.b_start_y) - spi_pkg::DIFF_W'(segs.a_start_y);
        wx_reg <= spi_pkg::DIFF_W'(segs.b_end_x) - spi_pkg::DIFF_W'(segs.a_start_x);
        wy_reg <= spi_pkg::DIFF_W'(segs.b_end_y) - spi_pkg::DIFF_W'(segs.a_start_y);
    end

    always_comb
    begin
        prod_next[P_RX_SY] = spi_pkg::mul(c1_reg.rx, c1_reg.sy);
        prod_next[P_RY_SX] = spi_pkg::mul(c1_reg.ry, c1_reg.sx);
        prod_next[P_QX_RY] = spi_pkg::mul(qx_reg, c1_reg.ry);
        prod_next[P_QY_RX] = spi_pkg::mul(qy_reg, c1_reg.rx);
        prod_next[P_RX_RX] = spi_pkg::mul(c1_reg.rx, c1_reg.rx);
        prod_next[P_RY_RY] = spi_pkg::mul(c1_reg.ry, c1_reg.ry);
        prod_next[P_QX_QX] = spi_pkg::mul(qx_reg, qx_reg);
        prod_next[P_QY_QY] = spi_pkg::mul(qy_reg, qy_reg);
        prod_next[P_QX_RX] = spi_pkg::mul(qx_reg, c1_reg.rx);
        prod_next[P_QY_RY] = spi_pkg::mul(qy_reg, c1_reg.ry);
        prod_next[P_WX_RX] = spi_pkg::mul(wx_reg, c1_reg.rx);
        prod_next[P_WY_RY] = spi_pkg::mul(wy_reg, c1_reg.ry);
        prod_next[P_QX_SY] = spi_pkg::mul(qx_reg, c1_reg.sy);
        prod_next[P_QY_SX] = spi_pkg::mul(qy_reg, c1_reg.sx);
        prod_next[P_SX_SX] = spi_pkg::mul(c1_reg.sx, c1_reg.sx);
        prod_next[P_SY_SY] = spi_pkg::mul(c1_reg.sy, c1_reg.sy);
    end

    always_ff @(posedge clk)
    begin
        c2_reg   <= c1_reg;
        prod_reg <= prod_next;
    end

    always_comb
    begin
        c3_next    = c2_reg;
        c3_next.ss = spi_pkg::SUM_W'(prod_reg[P_SX_SX]) + spi_pkg::SUM_W'(prod_reg[P_SY_SY]);
    end

    always_ff @(posedge clk)
    begin
        c3_reg   <= c3_next;
        rxs_reg  <= spi_pkg::SUM_W'(prod_reg[P_RX_SY]) - spi_pkg::SUM_W'(prod_reg[P_RY_SX]);
        qpxr_reg <= spi_pkg::SUM_W'(prod_reg[P_QX_RY]) - spi_pkg::SUM_W'(prod_reg[P_QY_RX]);
        rr_reg   <= spi_pkg::SUM_W'(prod_reg[P_RX_RX]) + spi_pkg::SUM_W'(prod_reg[P_RY_RY]);
        qq_reg   <= spi_pkg::SUM_W'(prod_reg[P_QX_QX]) + spi_pkg::SUM_W'(prod_reg[P_QY_QY]);
        qr_reg   <= spi_pkg::SUM_W'(prod_reg[P_QX_RX]) + spi_pkg::SUM_W'(prod_reg[P_QY_RY]);
        wr_reg   <= spi_pkg::SUM_W'(prod_reg[P_WX_RX]) + spi_pkg::SUM_W'(prod_reg[P_WY_RY]);
        qs_reg   <= spi_pkg::SUM_W'(prod_reg[P_QX_SY]) - spi_pkg::SUM_W'(prod_reg[P_QY_SX]);
    end

    // Collinear pairs project B's ends onto A; crossing pairs solve for t and u.
    always_comb
    begin
        col                      = spi_pkg::abs_le(rxs_reg, eps_f) &&
                                   spi_pkg::abs_le(qpxr_reg, eps_f);
        front_next.ctx           = c3_reg;
        front_next.ctx.col       = col;
        front_next.ctx.rxs_small = spi_pkg::abs_le(rxs_reg, eps_f);
        front_next.ctx.rr_small  = spi_pkg::le_sq(rr_reg, eps_sq);
        front_next.ctx.qq_small  = spi_pkg::le_sq(qq_reg, eps_sq);
        front_next.num_a         = col ? spi_pkg::shl_frac(qr_reg) : spi_pkg::shl_frac(qs_reg);
        front_next.num_b         = col ? spi_pkg::shl_frac(wr_reg) : spi_pkg::shl_frac(qpxr_reg);
        front_next.den           = col ? rr_reg : rxs_reg;
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
    end

    assign valid = v4_reg;
    assign front = front_reg;

endmodule

// ----- bench/segment_pair_intersect_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment pair intersection testbench
// Streams segment pairs into the block under several tolerance settings and
// checks every result transaction against an in-bench predictor, in order.
// ----------------------------------------------------------------------------
module segment_pair_intersect_test;

    typedef logic signed [127:0] wide_t;

    localparam int  LATENCY     = 54;
    localparam int  CYCLE_LIMIT = 400000;
    localparam longint UNIT     = 65536;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    spi_pkg::seg_in_t   segs = '0;
    logic               tol_wr_en = 1'b0;
    spi_pkg::tol_t      tol_wr_data = '0;
    logic               done;
    spi_pkg::seg_out_t  result;

    spi_pkg::tol_t      tol_now = spi_pkg::TOL_W'(1);
    spi_pkg::seg_out_t  expected_q[$];
    int       mismatches = 0;
    int       results_seen = 0;
    int       pairs_sent = 0;
    int       cycles = 0;
    int       hist[3] = '{0, 0, 0};

    segment_pair_intersect u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .segs(segs),
        .tol_wr_en(tol_wr_en), .tol_wr_data(tol_wr_data), .done(done), .result(result)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------ predictor
    function automatic wide_t wmul(longint a, longint b);
        wide_t x;
        wide_t y;
        x = a;
        y = b;
        return x * y;
    endfunction

    function automatic wide_t cross2(longint ax, longint ay, longint bx, longint by);
        return wmul(ax, by) - wmul(ay, bx);
    endfunction

    function automatic wide_t dot2(longint ax, longint ay, longint bx, longint by);
        return wmul(ax, bx) + wmul(ay, by);
    endfunction

    function automatic bit mag_within(wide_t a, longint lim);
        wide_t l;
        l = lim;
        return (a <= l) && (a >= -l);
    endfunction

    // Floor division, saturated to +-2^62.
    function automatic longint floor_div(wide_t n, wide_t d);
        logic [127:0] un;
        logic [127:0] ud;
        logic [127:0] q;
        logic [127:0] r;
        bit neg;
        neg = (n < 0) != (d < 0);
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = un / ud;
        r = un % ud;
        if (neg && r != 0)
        begin
            q = q + 1;
        end
        if (q > (128'd1 << 62))
        begin
            q = 128'd1 << 62;
        end
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic longint point_on(longint p0, longint d, longint t);
        wide_t w;
        w = wmul(d, t) >>> spi_pkg::FRACTION_BITS;
        return p0 + $signed(w[63:0]);
    endfunction

    function automatic longint clamp_unit(longint t);
        return t < 0 ? 0 : (t > UNIT ? UNIT : t);
    endfunction

    // Parameter of a point on segment B, zero when the point is off B.
    function automatic longint b_param(longint px, longint py, longint bx, longint by,
                                       longint dx, longint dy, longint eps,
                                       longint eps_f, longint eps_sq);
        longint apx;
        longint apy;
        longint t;
        wide_t len2;
        apx = px - bx;
        apy = py - by;
        if (!mag_within(cross2(dx, dy, apx, apy), eps_f))
        begin
            return 0;
        end
        len2 = dot2(dx, dy, dx, dy);
        if (len2 <= wide_t'(eps_sq))
        begin
            return 0;
        end
        t = floor_div(dot2(apx, apy, dx, dy) <<< spi_pkg::FRACTION_BITS, len2);
        if (t < -eps || t > UNIT + eps)
        begin
            return 0;
        end
        return clamp_unit(t);
    endfunction

    function automatic spi_pkg::seg_out_t predict_hit(spi_pkg::seg_in_t s, spi_pkg::tol_t tol);
        longint ax, ay, ex, ey, bx, by, fx, fy;
        longint eps, eps_f, eps_sq;
        longint rx, ry, sx, sy, qx, qy;
        longint ta, tb, hx, hy, t0, t1, lo, hi, k, t, u;
        spi_pkg::rel_t rel;
        wide_t rxs, qpxr, rr;
        spi_pkg::seg_out_t o;
        ax = s.a_start_x; ay = s.a_start_y; ex = s.a_end_x; ey = s.a_end_y;
        bx = s.b_start_x; by = s.b_start_y; fx = s.b_end_x; fy = s.b_end_y;
        eps = tol;
        eps_f = eps << spi_pkg::FRACTION_BITS;
        eps_sq = eps * eps;
        rx = ex - ax; ry = ey - ay; sx = fx - bx; sy = fy - by; qx = bx - ax; qy = by - ay;
        ta = 0; tb = 0; hx = 0; hy = 0;
        rel = spi_pkg::REL_NONE;
        rxs = cross2(rx, ry, sx, sy);
        qpxr = cross2(qx, qy, rx, ry);
        if (mag_within(rxs, eps_f) && mag_within(qpxr, eps_f))
        begin
            rr = dot2(rx, ry, rx, ry);
            if (rr <= wide_t'(eps_sq))
            begin
                // Degenerate A only meets B when both starts coincide.
                if (dot2(qx, qy, qx, qy) <= wide_t'(eps_sq))
                begin
                    rel = spi_pkg::REL_POINT; hx = ax; hy = ay;
                end
            end
            else
            begin
                t0 = floor_div(dot2(qx, qy, rx, ry) <<< spi_pkg::FRACTION_BITS, rr);
                t1 = floor_div(dot2(fx - ax, fy - ay, rx, ry) <<< spi_pkg::FRACTION_BITS, rr);
                if (t0 > t1)
                begin
                    k = t0; t0 = t1; t1 = k;
                end
                lo = t0 > 0 ? t0 : 0;
                hi = t1 < UNIT ? t1 : UNIT;
                if (!(hi < -eps || lo > UNIT + eps || hi < lo - eps))
                begin
                    if (hi - lo <= eps)
                    begin
                        rel = spi_pkg::REL_POINT;
                        ta = clamp_unit(lo);
                        hx = point_on(ax, rx, ta);
                        hy = point_on(ay, ry, ta);
                        tb = b_param(hx, hy, bx, by, sx, sy, eps, eps_f, eps_sq);
                    end
                    else
                    begin
                        rel = spi_pkg::REL_OVERLAP;
                        ta = lo; tb = hi;
                        hx = point_on(ax, rx, lo);
                        hy = point_on(ay, ry, lo);
                    end
                end
            end
        end
        else if (!mag_within(rxs, eps_f))
        begin
            t = floor_div(cross2(qx, qy, sx, sy) <<< spi_pkg::FRACTION_BITS, rxs);
            u = floor_div(qpxr <<< spi_pkg::FRACTION_BITS, rxs);
            if (t >= -eps && t <= UNIT + eps && u >= -eps && u <= UNIT + eps)
            begin
                rel = spi_pkg::REL_POINT;
                ta = clamp_unit(t);
                tb = clamp_unit(u);
                hx = point_on(ax, rx, ta);
                hy = point_on(ay, ry, ta);
            end
        end
        o.relation = rel;
        o.param_first = ta[spi_pkg::PARAM_W-1:0];
        o.param_second = tb[spi_pkg::PARAM_W-1:0];
        o.hit_x = hx[spi_pkg::COORD_WIDTH-1:0];
        o.hit_y = hy[spi_pkg::COORD_WIDTH-1:0];
        return o;
    endfunction

    // ------------------------------------------------------------------ checker
    always @(posedge clk)
    begin
        if (done)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result transaction: %p", result);
                end
            end
            else
            begin
                spi_pkg::seg_out_t e;
                e = expected_q.pop_front();
                hist[e.relation]++;
                if (result.relation !== e.relation || result.param_first !== e.param_first
                    || result.param_second !== e.param_second || result.hit_x !== e.hit_x
                    || result.hit_y !== e.hit_y)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected %p", e);
                        $display("          actual   %p", result);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("segment_pair_intersect_test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------ drivers
    task automatic send_pair(spi_pkg::seg_in_t s);
        int gap;
        segs <= s;
        start <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                break;
            end
        end
        expected_q.insert(expected_q.size(), predict_hit(s, tol_now));
        pairs_sent++;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0)
        begin
            gap = 0;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 6) @(posedge clk);
    endtask

    task automatic set_tolerance(spi_pkg::tol_t v);
        drain();
        tol_wr_en <= 1'b1;
        tol_wr_data <= v;
        @(posedge clk);
        tol_wr_en <= 1'b0;
        tol_now = v;
        @(posedge clk);
    endtask

    function automatic spi_pkg::seg_in_t mk(longint ax, longint ay, longint ex, longint ey,
                                            longint bx, longint by, longint fx, longint fy);
        spi_pkg::seg_in_t s;
        s.a_start_x = ax[31:0]; s.a_start_y = ay[31:0];
        s.a_end_x = ex[31:0]; s.a_end_y = ey[31:0];
        s.b_start_x = bx[31:0]; s.b_start_y = by[31:0];
        s.b_end_x = fx[31:0]; s.b_end_y = fy[31:0];
        return s;
    endfunction

    // Pairs on one line (with occasional jitter, offset or degenerate ends).
    function automatic spi_pkg::seg_in_t make_collinear();
        longint px, py, dx, dy, ox, oy;
        longint k[4];
        spi_pkg::seg_in_t s;
        px = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        py = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        dx = longint'($urandom_range(0, 1 << 17)) - (1 << 16);
        dy = longint'($urandom_range(0, 1 << 17)) - (1 << 16);
        foreach (k[i])
        begin
            k[i] = longint'($urandom_range(0, 8)) - 4;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            k[1] = k[0];
        end
        if ($urandom_range(0, 9) == 0)
        begin
            k[3] = k[2];
        end
        if ($urandom_range(0, 3) == 0)
        begin
            k[2] = k[$urandom_range(0, 1)];
        end
        ox = 0;
        oy = 0;
        if ($urandom_range(0, 7) == 0)
        begin
            ox = -dy / 64;
            oy = dx / 64;
        end
        s = mk(px + k[0] * dx / 4, py + k[0] * dy / 4, px + k[1] * dx / 4, py + k[1] * dy / 4,
               px + k[2] * dx / 4 + ox, py + k[2] * dy / 4 + oy,
               px + k[3] * dx / 4 + ox, py + k[3] * dy / 4 + oy);
        if ($urandom_range(0, 3) == 0)
        begin
            s.b_end_x = s.b_end_x + $signed(3'($urandom_range(0, 2))) - 1;
            s.b_start_y = s.b_start_y + $signed(3'($urandom_range(0, 2))) - 1;
        end
        return s;
    endfunction

    function automatic spi_pkg::seg_in_t make_crossing();
        longint c[8];
        foreach (c[i])
        begin
            c[i] = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
        end
        return mk(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endfunction

    function automatic spi_pkg::seg_in_t make_wild();
        spi_pkg::seg_in_t s;
        s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return s;
    endfunction

    // ------------------------------------------------------------------ tests
    task automatic test_directed();
        longint mx;
        longint mn;
        mx = 64'sh7fffffff;
        mn = -64'sh80000000;
        // Proper crossing, T junction, miss and parallel disjoint pairs.
        send_pair(mk(0, 0, 4 * UNIT, 4 * UNIT, 0, 4 * UNIT, 4 * UNIT, 0));
        send_pair(mk(0, 0, 4 * UNIT, 0, 2 * UNIT, 0, 2 * UNIT, 3 * UNIT));
        send_pair(mk(0, 0, UNIT, 0, 3 * UNIT, -UNIT, 3 * UNIT, UNIT));
        send_pair(mk(0, 0, 4 * UNIT, 0, 0, UNIT, 4 * UNIT, UNIT));
        // Collinear overlap, collinear disjoint and two end-to-end touches, the second with B reversed.
        send_pair(mk(0, 0, 4 * UNIT, 0, UNIT, 0, 6 * UNIT, 0));
        send_pair(mk(0, 0, UNIT, 0, 2 * UNIT, 0, 3 * UNIT, 0));
        send_pair(mk(0, 0, 2 * UNIT, 0, 2 * UNIT, 0, 5 * UNIT, 0));
        send_pair(mk(0, 0, 2 * UNIT, 0, 5 * UNIT, 0, 2 * UNIT, 0));
        // Touch where B is a single point.
        send_pair(mk(0, 0, 2 * UNIT, 0, 2 * UNIT, 0, 2 * UNIT, 0));
        // Degenerate A, at B's start and away from it.
        send_pair(mk(UNIT, UNIT, UNIT, UNIT, UNIT, UNIT, 3 * UNIT, 3 * UNIT));
        send_pair(mk(UNIT, UNIT, UNIT, UNIT, 2 * UNIT, 2 * UNIT, 3 * UNIT, 3 * UNIT));
        send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));
        // Reversed B covering all of A.
        send_pair(mk(0, 0, UNIT, UNIT, 3 * UNIT, 3 * UNIT, -UNIT, -UNIT));
        // Coordinate extremes.
        send_pair(mk(mn, mn, mx, mx, mn, mx, mx, mn));
        send_pair(mk(mx, mn, mn, mx, mx, mx, mn, mn));
        send_pair(mk(mn, 0, mx, 0, mn, 0, mx, 0));
        send_pair(mk(mx, mx, mx, mx, mx, mx, mn, mn));
        send_pair(mk(mn, mn, mn, mn, mx, mx, mx, mx));
        send_pair(mk(-1, -1, 1, 1, -1, 1, 1, -1));
    endtask

    task automatic test_random_mix(int count);
        int sel;
        repeat (count)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
            begin
                send_pair(make_collinear());
            end
            else if (sel < 8)
            begin
                send_pair(make_crossing());
            end
            else
            begin
                send_pair(make_wild());
            end
        end
    endtask

    task automatic test_tolerance_sweep();
        spi_pkg::tol_t t;
        set_tolerance(spi_pkg::TOL_W'(0));
        test_directed();
        test_random_mix(200);
        set_tolerance(17'd65536);
        test_directed();
        test_random_mix(200);
        repeat (4)
        begin
            t = 17'($urandom_range(0, 65536));
            if ($urandom_range(0, 1) == 0)
            begin
                t = 17'($urandom_range(0, 1024));
            end
            set_tolerance(t);
            test_random_mix(150);
        end
        set_tolerance(spi_pkg::TOL_W'(1));
        test_random_mix(200);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_mix(200);
        test_tolerance_sweep();
        drain();
        $display("%0d segment pairs sent over several tolerance settings, %0d results checked",
                 pairs_sent, results_seen);
        $display("relations seen: %0d none, %0d point, %0d overlap; %0d mismatches",
                 hist[0], hist[1], hist[2], mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
        begin
            $display("segment_pair_intersect_test passed");
        end
        else
        begin
            $display("segment_pair_intersect_test failed");
        end
        $finish;
    end

endmodule
